// ===== hdl/hic_pkg.sv =====
// ---------------------------------------------------------------------------
// hic_pkg
// shared constants, command codes and control structs of the hic15 tracker
// ---------------------------------------------------------------------------
package hic_pkg;

    localparam int WINDOW      = 15;
    localparam int SLOT_W      = $clog2(WINDOW);
    localparam int CNT_W       = 6;
    localparam int RAW_W       = 10;
    localparam int MAG_W       = 19;
    localparam int SQ_W        = 30;
    localparam int RAD_W       = 38;
    localparam int REM_W       = 21;
    localparam int ROOT_STEPS  = RAD_W / 2;
    localparam int PERIOD_W    = 16;
    localparam int PEAK_W      = 24;
    localparam int HIC_W       = 22;
    localparam int ACC_W       = 26;
    localparam int A_W         = 20;
    localparam int MUL_W       = 20;
    localparam int M_W         = 56;
    localparam int RECIP_SHIFT = PEAK_W - 1 + SLOT_W;
    localparam int PROD_W      = 2 * PEAK_W - 1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
    localparam logic [PEAK_W-1:0]   SUM_MAX      = 24'hFFFFFF;
    localparam logic [HIC_W-1:0]    HIC_MAX      = 22'h3FFFFF;
    // rounded-up reciprocal of the window length
    localparam logic [PEAK_W-1:0]   RECIP        =
        PEAK_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_SQ_X,
        CMD_SQ_Y,
        CMD_SQ_Z,
        CMD_RINIT_MAG,
        CMD_ROOT_STEP,
        CMD_STORE,
        CMD_SUM_STEP,
        CMD_PEAK,
        CMD_DIV,
        CMD_RINIT_A,
        CMD_MUL_AA,
        CMD_MUL_LO,
        CMD_MUL_HI,
        CMD_RESULT
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code        code;
        logic [CNT_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic report;
        logic out_busy;
    } t_status;

endpackage

// ===== hdl/hic_ctrl.sv =====
// ---------------------------------------------------------------------------
// hic_ctrl
// sequencer that issues the datapath commands for each sample
// ---------------------------------------------------------------------------
module hic_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  hic_pkg::t_status i_status,
    output logic            o_idle,
    output hic_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ROOT, S_STORE, S_DECIDE, S_CHECK,
        S_SUM, S_DIV, S_AROOT, S_MUL, S_WAIT
    } t_state;

    t_state                      r_state;
    logic [hic_pkg::CNT_W-1:0]   r_cnt;
    hic_pkg::t_cmd               r_cmd;

    assign o_idle = (r_state == S_IDLE);
    assign o_cmd  = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_cmd.code <= hic_pkg::CMD_NONE;
            r_cmd.idx  <= '0;
        end else begin
            r_cmd.code <= hic_pkg::CMD_NONE;
            r_cmd.idx  <= r_cnt;
            case (r_state)
                S_IDLE: begin
                    if (i_in_fire) begin
                        r_cmd.code <= hic_pkg::CMD_SQ_X;
                        r_cnt      <= 6'd1;
                        r_state    <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_cnt == 6'd1) begin
                        r_cmd.code <= hic_pkg::CMD_SQ_Y;
                        r_cnt      <= 6'd2;
                    end else if (r_cnt == 6'd2) begin
                        r_cmd.code <= hic_pkg::CMD_SQ_Z;
                        r_cnt      <= 6'd3;
                    end else begin
                        r_cmd.code <= hic_pkg::CMD_RINIT_MAG;
                        r_cnt      <= '0;
                        r_state    <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    r_cmd.code <= hic_pkg::CMD_ROOT_STEP;
                    r_cnt      <= r_cnt + 6'd1;
                    if (r_cnt == 6'(hic_pkg::ROOT_STEPS - 1)) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    r_cmd.code <= hic_pkg::CMD_STORE;
                    r_state    <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_cmd.idx <= '0;
                    r_cnt     <= 6'd1;
                    if (i_status.report) begin
                        r_cmd.code <= hic_pkg::CMD_DIV;
                        r_state    <= S_DIV;
                    end else begin
                        r_cmd.code <= hic_pkg::CMD_SUM_STEP;
                        r_state    <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_cnt == 6'(hic_pkg::WINDOW)) begin
                        r_cmd.code <= hic_pkg::CMD_PEAK;
                        r_state    <= S_IDLE;
                    end else begin
                        r_cmd.code <= hic_pkg::CMD_SUM_STEP;
                        r_cnt      <= r_cnt + 6'd1;
                    end
                end
                S_DIV: begin
                    r_cmd.code <= hic_pkg::CMD_RINIT_A;
                    r_cnt      <= '0;
                    r_state    <= S_AROOT;
                end
                S_AROOT: begin
                    r_cmd.code <= hic_pkg::CMD_ROOT_STEP;
                    r_cnt      <= r_cnt + 6'd1;
                    if (r_cnt == 6'(hic_pkg::ROOT_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_cmd.code <= hic_pkg::CMD_MUL_AA;
                    end else if (r_cnt == 6'd1) begin
                        r_cmd.code <= hic_pkg::CMD_MUL_LO;
                    end else begin
                        r_cmd.code <= hic_pkg::CMD_MUL_HI;
                        r_state    <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (!i_status.out_busy) begin
                        r_cmd.code <= hic_pkg::CMD_RESULT;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/hic_dp.sv =====
// ---------------------------------------------------------------------------
// hic_dp
// datapath: squares, bitwise square root, window ring and sum, divide, product
// ---------------------------------------------------------------------------
module hic_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hic_pkg::t_cmd                 i_cmd,
    input  logic                          i_in_fire,
    input  logic [hic_pkg::RAW_W-1:0]     i_sample_x,
    input  logic [hic_pkg::RAW_W-1:0]     i_sample_y,
    input  logic [hic_pkg::RAW_W-1:0]     i_sample_z,
    input  logic                          i_cfg_fire,
    input  logic [hic_pkg::PERIOD_W-1:0]  i_cfg_data,
    input  logic                          i_result_ready,
    output logic                          o_result_valid,
    output logic [hic_pkg::HIC_W-1:0]     o_hic_hundredths,
    output logic [hic_pkg::PEAK_W-1:0]    o_peak_sum,
    output hic_pkg::t_status              o_status
);

    logic [hic_pkg::RAW_W-1:0]    r_raw_x, r_raw_y, r_raw_z;
    logic [hic_pkg::PERIOD_W-1:0] r_period;
    logic [hic_pkg::SQ_W-1:0]     r_sq;
    logic [hic_pkg::RAD_W-1:0]    r_rad;
    logic [hic_pkg::MAG_W-1:0]    r_root;
    logic [hic_pkg::REM_W-1:0]    r_rem;
    logic [hic_pkg::MAG_W-1:0]    r_ring [hic_pkg::WINDOW];
    logic [hic_pkg::SLOT_W-1:0]   r_slot;
    logic [hic_pkg::PERIOD_W-1:0] r_count;
    logic [hic_pkg::PEAK_W-1:0]   r_peak;
    logic                         r_report;
    logic [hic_pkg::ACC_W-1:0]    r_acc;
    logic [hic_pkg::A_W-1:0]      r_quot;
    logic [2*hic_pkg::MUL_W-1:0]  r_p;
    logic [hic_pkg::M_W-1:0]      r_m;
    logic                         r_out_valid;
    logic [hic_pkg::HIC_W-1:0]    r_hic;
    logic [hic_pkg::PEAK_W-1:0]   r_peak_out;

    function automatic logic [13:0] abs_axis(input logic [hic_pkg::RAW_W-1:0] raw);
        logic [15:0] v;
        v = 16'(raw) * 16'd25 - 16'd12800;
        abs_axis = v[15] ? 14'(-v) : v[13:0];
    endfunction

    logic [hic_pkg::MUL_W-1:0]   w_mul_a, w_mul_b;
    logic [2*hic_pkg::MUL_W-1:0] w_prod;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.code)
            hic_pkg::CMD_SQ_X: begin
                w_mul_a = 20'(abs_axis(r_raw_x));
                w_mul_b = w_mul_a;
            end
            hic_pkg::CMD_SQ_Y: begin
                w_mul_a = 20'(abs_axis(r_raw_y));
                w_mul_b = w_mul_a;
            end
            hic_pkg::CMD_SQ_Z: begin
                w_mul_a = 20'(abs_axis(r_raw_z));
                w_mul_b = w_mul_a;
            end
            hic_pkg::CMD_MUL_AA: begin
                w_mul_a = r_quot[hic_pkg::A_W-1:0];
                w_mul_b = r_quot[hic_pkg::A_W-1:0];
            end
            hic_pkg::CMD_MUL_LO: begin
                w_mul_a = r_p[hic_pkg::MUL_W-1:0];
                w_mul_b = 20'(r_root);
            end
            hic_pkg::CMD_MUL_HI: begin
                w_mul_a = r_p[2*hic_pkg::MUL_W-1:hic_pkg::MUL_W];
                w_mul_b = 20'(r_root);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // root step
    logic [hic_pkg::REM_W-1:0] w_rem_sh, w_trial;
    assign w_rem_sh = {r_rem[hic_pkg::REM_W-3:0], r_rad[hic_pkg::RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};

    // window sum
    logic [hic_pkg::SLOT_W-1:0] w_idx, w_newest;
    logic [hic_pkg::ACC_W-1:0]  w_term;
    logic [16:0]                w_next;
    assign w_idx    = i_cmd.idx[hic_pkg::SLOT_W-1:0];
    assign w_newest = (r_slot == '0) ? hic_pkg::SLOT_W'(hic_pkg::WINDOW - 1)
                                     : r_slot - hic_pkg::SLOT_W'(1);
    assign w_term   = (w_idx == w_newest || w_idx == r_slot)
                    ? hic_pkg::ACC_W'(r_ring[w_idx])
                    : hic_pkg::ACC_W'({r_ring[w_idx], 1'b0});
    assign w_next   = 17'(r_count) + 17'd1;

    logic [hic_pkg::PEAK_W-1:0] w_sat;
    assign w_sat = (r_acc > hic_pkg::ACC_W'(hic_pkg::SUM_MAX)) ? hic_pkg::SUM_MAX
                                                               : r_acc[hic_pkg::PEAK_W-1:0];

    // half the peak times the window reciprocal
    logic [hic_pkg::PROD_W-1:0] w_recip_prod;
    assign w_recip_prod = hic_pkg::PROD_W'(r_peak[hic_pkg::PEAK_W-1:1])
                        * hic_pkg::PROD_W'(hic_pkg::RECIP);

    // final scale
    logic [hic_pkg::M_W:0] w_t3;
    logic [25:0]           w_hic;
    assign w_t3  = {r_m, 1'b0} + {1'b0, r_m};
    assign w_hic = w_t3[hic_pkg::M_W:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= hic_pkg::PERIOD_RESET;
            r_slot      <= '0;
            r_count     <= '0;
            r_peak      <= '0;
            r_report    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < hic_pkg::WINDOW; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (i_cfg_fire) begin
                r_period <= i_cfg_data;
            end
            if (r_out_valid && i_result_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.code)
                hic_pkg::CMD_STORE: begin
                    r_ring[r_slot] <= r_root;
                    r_slot <= (r_slot == hic_pkg::SLOT_W'(hic_pkg::WINDOW - 1))
                            ? '0 : r_slot + hic_pkg::SLOT_W'(1);
                    r_report <= (w_next > {1'b0, r_period});
                    if (!(w_next > {1'b0, r_period})) begin
                        r_count <= w_next[hic_pkg::PERIOD_W-1:0];
                    end
                end
                hic_pkg::CMD_PEAK: begin
                    if (w_sat > r_peak) begin
                        r_peak <= w_sat;
                    end
                end
                hic_pkg::CMD_RESULT: begin
                    r_out_valid <= 1'b1;
                    r_slot      <= '0;
                    r_count     <= '0;
                    r_peak      <= '0;
                    for (int i = 0; i < hic_pkg::WINDOW; i++) begin
                        r_ring[i] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_raw_x <= i_sample_x;
            r_raw_y <= i_sample_y;
            r_raw_z <= i_sample_z;
        end
        case (i_cmd.code)
            hic_pkg::CMD_SQ_X: begin
                r_sq <= hic_pkg::SQ_W'(w_prod);
            end
            hic_pkg::CMD_SQ_Y, hic_pkg::CMD_SQ_Z: begin
                r_sq <= r_sq + hic_pkg::SQ_W'(w_prod);
            end
            hic_pkg::CMD_RINIT_MAG: begin
                r_rad  <= {r_sq, 8'd0};
                r_root <= '0;
                r_rem  <= '0;
            end
            hic_pkg::CMD_RINIT_A: begin
                r_rad  <= hic_pkg::RAD_W'({r_quot[hic_pkg::A_W-1:0], 10'd0});
                r_root <= '0;
                r_rem  <= '0;
            end
            hic_pkg::CMD_ROOT_STEP: begin
                r_rad <= {r_rad[hic_pkg::RAD_W-3:0], 2'b00};
                if (w_rem_sh >= w_trial) begin
                    r_rem  <= w_rem_sh - w_trial;
                    r_root <= {r_root[hic_pkg::MAG_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh;
                    r_root <= {r_root[hic_pkg::MAG_W-2:0], 1'b0};
                end
            end
            hic_pkg::CMD_SUM_STEP: begin
                r_acc <= ((i_cmd.idx == '0) ? '0 : r_acc) + w_term;
            end
            hic_pkg::CMD_DIV: begin
                r_quot <= w_recip_prod[hic_pkg::RECIP_SHIFT +: hic_pkg::A_W];
            end
            hic_pkg::CMD_MUL_AA: begin
                r_p <= w_prod;
            end
            hic_pkg::CMD_MUL_LO: begin
                r_m <= hic_pkg::M_W'(w_prod);
            end
            hic_pkg::CMD_MUL_HI: begin
                r_m <= r_m + hic_pkg::M_W'({w_prod, 20'd0});
            end
            hic_pkg::CMD_RESULT: begin
                r_hic      <= (w_hic > 26'(hic_pkg::HIC_MAX)) ? hic_pkg::HIC_MAX
                                                               : w_hic[hic_pkg::HIC_W-1:0];
                r_peak_out <= r_peak;
            end
            default: begin
            end
        endcase
    end

    assign o_result_valid   = r_out_valid;
    assign o_hic_hundredths = r_hic;
    assign o_peak_sum       = r_peak_out;
    assign o_status.report   = r_report;
    assign o_status.out_busy = r_out_valid && !i_result_ready;

endmodule

// ===== hdl/head_injury_criterion_tracker.sv =====
// ---------------------------------------------------------------------------
// head_injury_criterion_tracker
// tracks the peak 15-sample trapezoid window of acceleration magnitude and
// reports a head injury criterion value once every report_period + 1 samples
//
// sample channel: i_sample_valid / o_sample_ready with x, y, z readings.
// result channel: o_result_valid / i_result_ready with hic and peak sum.
// config channel: i_cfg_valid / o_cfg_ready writes report_period, always ready.
// a sample with no report due runs the square/setup steps, 19 root
// iterations, store, decide, the 15-slot window sum and a peak update;
// a reporting sample runs a reciprocal divide, a root setup, 19 more root
// iterations, the multiply steps and the result load in place of the sum,
// and its result goes valid once the output register is free.
// the single shared root unit and the one 20x20 multiplier do this work in turn.
// a result sits in an output register; the next sample is taken while it
// waits, and a following result waits until the first transfer completes.
// reset clears the window, counters and output valid, and sets the period
// to 1000.
// ---------------------------------------------------------------------------
module head_injury_criterion_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_sample_valid,
    output logic                          o_sample_ready,
    input  logic [hic_pkg::RAW_W-1:0]     i_sample_x,
    input  logic [hic_pkg::RAW_W-1:0]     i_sample_y,
    input  logic [hic_pkg::RAW_W-1:0]     i_sample_z,
    output logic                          o_result_valid,
    input  logic                          i_result_ready,
    output logic [hic_pkg::HIC_W-1:0]     o_hic_hundredths,
    output logic [hic_pkg::PEAK_W-1:0]    o_peak_sum,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hic_pkg::PERIOD_W-1:0]  i_cfg_report_period
);

    hic_pkg::t_cmd    w_cmd;
    hic_pkg::t_status w_status;
    logic             w_idle;
    logic             w_in_fire;

    assign o_sample_ready = w_idle;
    assign o_cfg_ready    = 1'b1;
    assign w_in_fire      = i_sample_valid && w_idle;

    hic_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (w_in_fire),
        .i_status  (w_status),
        .o_idle    (w_idle),
        .o_cmd     (w_cmd)
    );

    hic_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_in_fire        (w_in_fire),
        .i_sample_x       (i_sample_x),
        .i_sample_y       (i_sample_y),
        .i_sample_z       (i_sample_z),
        .i_cfg_fire       (i_cfg_valid),
        .i_cfg_data       (i_cfg_report_period),
        .i_result_ready   (i_result_ready),
        .o_result_valid   (o_result_valid),
        .o_hic_hundredths (o_hic_hundredths),
        .o_peak_sum       (o_peak_sum),
        .o_status         (w_status)
    );

`ifndef NO_ASSERTIONS
    a_result_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.code == hic_pkg::CMD_RESULT |=> o_result_valid)
        else $error("result command did not raise valid");

    a_idle_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sample_ready |-> (w_cmd.code == hic_pkg::CMD_NONE ||
                            w_cmd.code == hic_pkg::CMD_RESULT ||
                            w_cmd.code == hic_pkg::CMD_PEAK))
        else $error("sample ready while datapath busy");

    a_result_not_overwritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.code == hic_pkg::CMD_RESULT |-> !$past(w_status.out_busy))
        else $error("pending result overwritten");
`endif

endmodule

// ===== tb/tb_head_injury_criterion_tracker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_head_injury_criterion_tracker
// self-checking bench for the hic15 tracker: a bit-exact predictor of the
// magnitude ring, trapezoid window peak and criterion value runs beside the
// block, driven by bursty samples, a stalling receiver and period writes
// ---------------------------------------------------------------------------
module tb_head_injury_criterion_tracker;

    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int SETTLE       = 100;

    typedef struct {
        logic [hic_pkg::HIC_W-1:0]  hic;
        logic [hic_pkg::PEAK_W-1:0] peak;
    } t_report;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_sample_valid;
    logic                         o_sample_ready;
    logic [hic_pkg::RAW_W-1:0]    i_sample_x;
    logic [hic_pkg::RAW_W-1:0]    i_sample_y;
    logic [hic_pkg::RAW_W-1:0]    i_sample_z;
    logic                         o_result_valid;
    logic                         i_result_ready;
    logic [hic_pkg::HIC_W-1:0]    o_hic_hundredths;
    logic [hic_pkg::PEAK_W-1:0]   o_peak_sum;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [hic_pkg::PERIOD_W-1:0] i_cfg_report_period;

    // predictor state
    logic [hic_pkg::MAG_W-1:0]    mag_ring [hic_pkg::WINDOW];
    int                           next_slot;
    logic [hic_pkg::PERIOD_W-1:0] tick_cnt;
    logic [hic_pkg::PEAK_W-1:0]   peak_win;
    logic [hic_pkg::PERIOD_W-1:0] period;

    t_report             pending_reports [$];
    int                  fail_count;
    int                  cycle_count;
    int                  burst_left;
    bit                  no_gaps;
    int                  hold_gen;
    int                  hold_seen;
    int                  hold_left;
    int                  rx_mode;
    int                  rx_phase;

    head_injury_criterion_tracker u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_sample_valid      (i_sample_valid),
        .o_sample_ready      (o_sample_ready),
        .i_sample_x          (i_sample_x),
        .i_sample_y          (i_sample_y),
        .i_sample_z          (i_sample_z),
        .o_result_valid      (o_result_valid),
        .i_result_ready      (i_result_ready),
        .o_hic_hundredths    (o_hic_hundredths),
        .o_peak_sum          (o_peak_sum),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_report_period (i_cfg_report_period)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint centred(logic [hic_pkg::RAW_W-1:0] raw);
        return longint'(raw) * 25 - 12800;
    endfunction

    task automatic clear_tracker();
        for (int i = 0; i < hic_pkg::WINDOW; i++) mag_ring[i] = '0;
        next_slot = 0;
        tick_cnt  = '0;
        peak_win  = '0;
    endtask

    task automatic predict_sample(logic [hic_pkg::RAW_W-1:0] x,
                                  logic [hic_pkg::RAW_W-1:0] y,
                                  logic [hic_pkg::RAW_W-1:0] z);
        longint      vx, vy, vz;
        logic [63:0] mag, a, r, hic, total;
        logic [16:0] nxt;
        int          newest;
        t_report     rep;
        vx  = centred(x);
        vy  = centred(y);
        vz  = centred(z);
        mag = int_sqrt(64'(vx * vx + vy * vy + vz * vz) * 256);
        if (mag > 64'h7FFFF) mag = 64'h7FFFF;
        mag_ring[next_slot] = mag[hic_pkg::MAG_W-1:0];
        next_slot = (next_slot + 1) % hic_pkg::WINDOW;
        nxt = {1'b0, tick_cnt} + 17'd1;
        if (nxt > {1'b0, period}) begin
            a   = 64'(peak_win) / (2 * hic_pkg::WINDOW);
            r   = int_sqrt(1024 * a);
            hic = (3 * a * a * r) >> 31;
            rep.hic  = (hic > 64'(hic_pkg::HIC_MAX)) ? hic_pkg::HIC_MAX
                                                     : hic[hic_pkg::HIC_W-1:0];
            rep.peak = peak_win;
            pending_reports.push_back(rep);
            clear_tracker();
        end else begin
            tick_cnt = nxt[hic_pkg::PERIOD_W-1:0];
            newest   = (next_slot + hic_pkg::WINDOW - 1) % hic_pkg::WINDOW;
            total    = 0;
            for (int i = 0; i < hic_pkg::WINDOW; i++)
                total += (i == newest || i == next_slot) ? 64'(mag_ring[i])
                                                         : 2 * 64'(mag_ring[i]);
            if (total > 64'(hic_pkg::SUM_MAX)) total = 64'(hic_pkg::SUM_MAX);
            if (total[hic_pkg::PEAK_W-1:0] > peak_win) peak_win = total[hic_pkg::PEAK_W-1:0];
        end
    endtask

    // returns at the edge of the transfer with valid still high
    task automatic send_sample(logic [hic_pkg::RAW_W-1:0] x,
                               logic [hic_pkg::RAW_W-1:0] y,
                               logic [hic_pkg::RAW_W-1:0] z);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (!no_gaps && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 30);
        end
        burst_left--;
        if (gap > 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample_x     <= x;
        i_sample_y     <= y;
        i_sample_z     <= z;
        do @(posedge i_clk); while (!(i_sample_valid && o_sample_ready));
        predict_sample(x, y, z);
    endtask

    task automatic send_random(int n);
        logic [hic_pkg::RAW_W-1:0] v [3];
        for (int k = 0; k < n; k++) begin
            for (int j = 0; j < 3; j++)
                v[j] = ($urandom_range(0, 2) == 0)
                     ? hic_pkg::RAW_W'($urandom_range(480, 544))
                     : hic_pkg::RAW_W'($urandom());
            send_sample(v[0], v[1], v[2]);
        end
        i_sample_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_period(logic [hic_pkg::PERIOD_W-1:0] value);
        wait_drained();
        i_cfg_valid         <= 1'b1;
        i_cfg_report_period <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        period = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_sample_extremes();
        send_sample('0, '0, '0);
        send_sample('1, '1, '1);
        send_sample(10'd512, 10'd512, 10'd512);
        send_sample('1, '0, 10'd512);
        send_sample(10'd511, 10'd513, 10'd0);
        send_sample(10'd1023, 10'd1023, 10'd0);
        send_sample(10'h2AA, 10'h155, 10'h3FF);
        send_sample(10'h155, 10'h2AA, 10'h000);
        i_sample_valid <= 1'b0;
    endtask

    task automatic test_partial_window();
        write_period(16'd5);
        for (int k = 0; k < 12; k++) send_sample('1, '1, '1);
        i_sample_valid <= 1'b0;
        write_period(16'd20);
        for (int k = 0; k < 21; k++) send_sample('1, '0, '1);
        i_sample_valid <= 1'b0;
    endtask

    task automatic test_period_extremes();
        write_period(16'd0);
        send_random(6);
        write_period(16'd1);
        send_random(6);
        write_period(16'hFFFF);
        send_random(20);
        // count stays above the new period, next sample reports
        write_period(16'd3);
        send_random(8);
    endtask

    task automatic test_long_period();
        write_period(16'd120);
        send_random(121);
    endtask

    task automatic test_backpressure();
        write_period(16'd1);
        no_gaps = 1'b1;
        hold_gen++;
        send_random(40);
        no_gaps = 1'b0;
    endtask

    task automatic test_random();
        for (int p = 0; p < 14; p++) begin
            write_period(hic_pkg::PERIOD_W'($urandom_range(1, 30)));
            no_gaps = ($urandom_range(0, 3) == 0);
            send_random(20);
        end
        no_gaps = 1'b0;
    endtask

    // receiver: ready pattern, long hold on request, result checking
    always @(posedge i_clk) begin
        t_report exp_rep;
        if (i_rst_n && o_result_valid && i_result_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result hic=%0d peak=%0d", $time,
                         o_hic_hundredths, o_peak_sum);
                fail_count++;
            end else begin
                exp_rep = pending_reports.pop_front();
                if (o_hic_hundredths !== exp_rep.hic) begin
                    $display("%0t: hic_hundredths expected %0d actual %0d", $time,
                             exp_rep.hic, o_hic_hundredths);
                    fail_count++;
                end
                if (o_peak_sum !== exp_rep.peak) begin
                    $display("%0t: peak_sum expected %0d actual %0d", $time,
                             exp_rep.peak, o_peak_sum);
                    fail_count++;
                end
            end
        end
        if (hold_seen != hold_gen) begin
            hold_seen = hold_gen;
            hold_left = 3000;
        end
        rx_phase++;
        if (rx_phase >= 97) begin
            rx_phase = 0;
            rx_mode  = $urandom_range(0, 3);
        end
        if (hold_left > 0) begin
            hold_left--;
            i_result_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: i_result_ready <= 1'b1;
                1: i_result_ready <= 1'($urandom_range(0, 1));
                2: i_result_ready <= ($urandom_range(0, 7) == 0);
                default: i_result_ready <= rx_phase[0];
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        i_sample_valid      <= 1'b0;
        i_sample_x          <= '0;
        i_sample_y          <= '0;
        i_sample_z          <= '0;
        i_result_ready      <= 1'b0;
        i_cfg_valid         <= 1'b0;
        i_cfg_report_period <= '0;
        fail_count  = 0;
        cycle_count = 0;
        burst_left  = 0;
        no_gaps     = 1'b0;
        hold_gen    = 0;
        hold_seen   = 0;
        hold_left   = 0;
        rx_mode     = 0;
        rx_phase    = 0;
        period      = hic_pkg::PERIOD_RESET;
        clear_tracker();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_sample_extremes();
        test_partial_window();
        test_period_extremes();
        test_backpressure();
        test_random();
        test_long_period();

        wait_drained();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
